/* rtl/tmdm_pkg.sv */
package tmdm_pkg;

    // Field widths fixed by the word formats
    localparam int SAMPLE_BITS = 16;
    localparam int AVG_BITS    = 24;
    localparam int FRAC_BITS   = 8;
    localparam int STATUS_BITS = 2;

    // Default set length limit
    localparam int MAX_SAMPLES = 128;

    // Status codes
    localparam logic [STATUS_BITS-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_FEW  = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_MANY = 2'd2;

    // Input word: one sample of a set
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          last;
    } in_word_t;

    // Output word: trimmed mean and status
    typedef struct packed {
        logic signed [AVG_BITS-1:0]    average;
        logic        [STATUS_BITS-1:0] status;
    } out_word_t;

endpackage

/* rtl/trimmed_mean_drop_min_max.sv */
// Trimmed mean of a set of signed samples, dropping one largest and one
// smallest sample, result in signed fixed point with 8 fraction bits.
//
// Input: a word (sample, last) is taken at a rising edge with start high and
// busy low. Samples of a set come one per cycle; busy stays low while a set
// is being summed, so a sample can be taken every cycle.
// When the word marked last is taken, busy rises and the block works out
// (sum - max - min) / (count - 2) with a restoring divider that settles one
// quotient bit per cycle. For a set with fewer than three or more than
// MAX_SAMPLES samples the trim state reports the status with average 0
// and no division is done.
// Output: result is valid for exactly one cycle while done is high; busy is
// low in that cycle and the next set may start. The receiver cannot stall.
// Reset (rst_n low, asynchronous) drops any set in progress and clears the
// count, sum, largest and smallest sample.
module trimmed_mean_drop_min_max #(
    parameter int MAX_SAMPLES = tmdm_pkg::MAX_SAMPLES
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  tmdm_pkg::in_word_t  item,
    output logic                done,
    output tmdm_pkg::out_word_t result
);

    localparam int SB     = tmdm_pkg::SAMPLE_BITS;
    localparam int AW     = tmdm_pkg::AVG_BITS;
    localparam int CNT_W  = $clog2(MAX_SAMPLES + 2);
    localparam int SUM_W  = SB + $clog2(MAX_SAMPLES + 1);
    localparam int TRIM_W = SUM_W + 2;
    localparam int NUM_W  = TRIM_W + tmdm_pkg::FRAC_BITS;
    localparam int ITER_W = $clog2(NUM_W + 1);
    localparam int QX_W   = (NUM_W > AW) ? NUM_W : AW + 1;

    localparam logic [QX_W-1:0] POS_LIM = QX_W'((64'd1 << (AW - 1)) - 64'd1);
    localparam logic [QX_W-1:0] NEG_LIM = QX_W'(64'd1 << (AW - 1));

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SAMPLES);
    localparam logic [CNT_W-1:0] CNT_MIN = CNT_W'(3);
    localparam logic [CNT_W-1:0] CNT_TWO = CNT_W'(2);

    // Sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_TRIM = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]              state_reg, state_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic signed [SB-1:0]    max_reg, max_next;
    logic signed [SB-1:0]    min_reg, min_next;
    logic [CNT_W-1:0]        div_reg, div_next;
    logic [CNT_W-1:0]        rem_reg, rem_next;
    logic [NUM_W-1:0]        quo_reg, quo_next;
    logic                    neg_reg, neg_next;
    logic [ITER_W-1:0]       iter_reg, iter_next;
    logic                    done_reg, done_next;
    tmdm_pkg::out_word_t     res_reg, res_next;

    logic                     take;
    logic signed [SUM_W-1:0]  s_ext;
    logic signed [TRIM_W-1:0] trim;
    logic [TRIM_W-1:0]        trim_mag;
    logic [CNT_W:0]           rem_sh;
    logic                     fits;
    logic [QX_W-1:0]          q_ext;
    logic [AW-1:0]            q_sat;

    assign busy   = (state_reg != S_IDLE);
    assign take   = start && !busy;
    assign done   = done_reg;
    assign result = res_reg;

    // Datapath helpers: sample extension, trimmed sum, divider step, saturation
    always_comb
    begin
        s_ext    = SUM_W'(item.sample);
        trim     = TRIM_W'(sum_reg) - TRIM_W'(max_reg) - TRIM_W'(min_reg);
        trim_mag = trim[TRIM_W-1] ? TRIM_W'(-trim) : TRIM_W'(trim);
        rem_sh   = {rem_reg, quo_reg[NUM_W-1]};
        fits     = (rem_sh >= {1'b0, div_reg});
        q_ext    = QX_W'(quo_reg);
        if (!neg_reg && (q_ext > POS_LIM))
        begin
            q_sat = AW'(POS_LIM);
        end
        else if (neg_reg && (q_ext > NEG_LIM))
        begin
            q_sat = AW'(NEG_LIM);
        end
        else
        begin
            q_sat = quo_reg[AW-1:0];
        end
    end

    // Sequencer and next-state values
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        sum_next   = sum_reg;
        max_next   = max_reg;
        min_next   = min_reg;
        div_next   = div_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        neg_next   = neg_reg;
        iter_next  = iter_reg;
        done_next  = 1'b0;
        res_next   = res_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    // accumulate until the count passes the limit
                    if (count_reg <= CNT_MAX)
                    begin
                        if (count_reg == '0)
                        begin
                            max_next = item.sample;
                            min_next = item.sample;
                        end
                        else
                        begin
                            if (item.sample > max_reg)
                            begin
                                max_next = item.sample;
                            end
                            if (item.sample < min_reg)
                            begin
                                min_next = item.sample;
                            end
                        end
                        sum_next   = sum_reg + s_ext;
                        count_next = count_reg + CNT_W'(1);
                    end
                    if (item.last)
                    begin
                        state_next = S_TRIM;
                    end
                end
            end

            S_TRIM:
            begin
                // set up the divider or report a bad set length
                div_next  = count_reg - CNT_TWO;
                rem_next  = '0;
                quo_next  = {trim_mag, {tmdm_pkg::FRAC_BITS{1'b0}}};
                neg_next  = trim[TRIM_W-1];
                iter_next = ITER_W'(NUM_W);
                count_next = '0;
                sum_next   = '0;
                max_next   = '0;
                min_next   = '0;
                if (count_reg > CNT_MAX)
                begin
                    res_next.average = '0;
                    res_next.status  = tmdm_pkg::ST_MANY;
                    done_next        = 1'b1;
                    state_next       = S_IDLE;
                end
                else if (count_reg < CNT_MIN)
                begin
                    res_next.average = '0;
                    res_next.status  = tmdm_pkg::ST_FEW;
                    done_next        = 1'b1;
                    state_next       = S_IDLE;
                end
                else
                begin
                    state_next = S_DIV;
                end
            end

            S_DIV:
            begin
                // one quotient bit per cycle
                rem_next  = fits ? CNT_W'(rem_sh - {1'b0, div_reg}) : CNT_W'(rem_sh);
                quo_next  = {quo_reg[NUM_W-2:0], fits};
                iter_next = iter_reg - ITER_W'(1);
                if (iter_reg == ITER_W'(1))
                begin
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                // restore sign, already saturated
                res_next.average = neg_reg ? -q_sat : q_sat;
                res_next.status  = tmdm_pkg::ST_OK;
                done_next        = 1'b1;
                state_next       = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            sum_reg   <= '0;
            max_reg   <= '0;
            min_reg   <= '0;
            iter_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
            max_reg   <= max_next;
            min_reg   <= min_next;
            iter_reg  <= iter_next;
            done_reg  <= done_next;
        end
    end

    // Divider and result payload
    always_ff @(posedge clk)
    begin
        div_reg <= div_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        neg_reg <= neg_next;
        res_reg <= res_next;
    end

endmodule
